@@ sv/sha256_pkg.sv @@
// sha256_pkg: shared constants, types and functions of the sha-256 hasher
// no dependencies
package sha256_pkg;

    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 64;

    typedef logic [31:0] word_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;

    localparam logic ACT_ABSORB = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    typedef struct packed {
        logic  start;
        word_t w;
        logic  [5:0] round;
    } round_ctl_t;

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t initial_hash(input logic [2:0] i);
        case (i)
            3'd0: initial_hash = 32'h6a09e667;
            3'd1: initial_hash = 32'hbb67ae85;
            3'd2: initial_hash = 32'h3c6ef372;
            3'd3: initial_hash = 32'ha54ff53a;
            3'd4: initial_hash = 32'h510e527f;
            3'd5: initial_hash = 32'h9b05688c;
            3'd6: initial_hash = 32'h1f83d9ab;
            default: initial_hash = 32'h5be0cd19;
        endcase
    endfunction

    function automatic word_t round_k(input logic [5:0] i);
        case (i)
            6'd0: round_k = 32'h428a2f98;   6'd1: round_k = 32'h71374491;
            6'd2: round_k = 32'hb5c0fbcf;   6'd3: round_k = 32'he9b5dba5;
            6'd4: round_k = 32'h3956c25b;   6'd5: round_k = 32'h59f111f1;
            6'd6: round_k = 32'h923f82a4;   6'd7: round_k = 32'hab1c5ed5;
            6'd8: round_k = 32'hd807aa98;   6'd9: round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;  default: round_k = 32'hc67178f2;
        endcase
    endfunction

endpackage

@@ sv/sha256_round.sv @@
// sha256_round: working variables a..h, one compression round per cycle
// depends on sha256_pkg
module sha256_round (
    input  logic                    aclk,
    input  sha256_pkg::round_ctl_t  ctl,
    input  sha256_pkg::word_t       chain_in [8],
    output sha256_pkg::word_t       vars_out [8]
);
    import sha256_pkg::*;

    word_t v_reg [8];
    word_t t1;
    word_t t2;

    assign t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + round_k(ctl.round) + ctl.w;
    assign t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            for (int i = 0; i < 8; i++) v_reg[i] <= chain_in[i];
        end else begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    assign vars_out = v_reg;

endmodule

@@ sv/sha256_message_hasher.sv @@
// sha256_message_hasher: byte-fed sha-256 hasher, top level
// depends on sha256_pkg and sha256_round
//
// usage:
//   s_axis carries one transaction per message byte; tuser = action
//   (0 absorb tdata byte, 1 finish). m_axis returns the digest as eight
//   32-bit words, first digest byte in tdata[31:24], word index in tuser,
//   tlast on the eighth word.
//   an absorb is taken while idle; the 64th byte of a block then holds the input
//   off through the 64 rounds and the chain update, so no byte of the next block
//   is taken until the block is compressed. the shared round unit sets the rate.
//   a finish with n pending bytes shifts in 64-n pad bytes, one per cycle,
//   then runs 64 rounds and 1 update; for n > 55 a full 64-byte pad block
//   follows the same way. the first digest word is valid after the update of
//   the last block, then the eight words go out one per accepted output
//   transaction.
//   s_axis_tready is low while padding, compressing or while digest words wait.
//   a stalled receiver holds the current word; nothing is dropped.
//   reset (aresetn low, synchronous) restores the initial hash, clears
//   the bit count and fill count; the block buffer keeps stale contents.
module sha256_message_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [2:0]  m_axis_tuser,   // word_index
    output logic        m_axis_tlast    // last_word
);
    import sha256_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_UPD   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    localparam logic [5:0] LAST_ROUND = 6'(ROUNDS - 1);

    state_t      state_reg, state_next;
    word_t       chain_reg [8];
    logic [63:0] bit_count_reg;
    logic [6:0]  fill_reg;
    word_t       w_reg [16];
    logic [5:0]  round_reg;
    logic        final_reg;     // compression ends the message
    logic        second_reg;    // another padded block follows
    logic [2:0]  out_idx_reg;
    logic [5:0]  pad_idx_reg;
    logic [63:0] len_reg;

    round_ctl_t  ctl;
    word_t       vars [8];
    word_t       w_new;
    word_t       w_cur;
    logic        s_fire;
    logic        m_fire;
    logic [7:0]  pad_byte;
    logic        shift_en;
    logic [7:0]  shift_byte;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_fire = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata = chain_reg[out_idx_reg];
    assign m_axis_tuser = out_idx_reg;
    assign m_axis_tlast = (out_idx_reg == 3'd7);

    // message schedule in a 16-word sliding window
    assign w_cur = w_reg[0];
    assign w_new = w_reg[0] + w_reg[9]
                 + (rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3))
                 + (rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10));

    assign ctl = {(state_reg != ST_ROUND), w_cur, round_reg};

    sha256_round u_round (
        .aclk     (aclk),
        .ctl      (ctl),
        .chain_in (chain_reg),
        .vars_out (vars)
    );

    // padding byte at the pad sweep position
    always_comb begin
        if (!fill_reg[6] && pad_idx_reg == fill_reg[5:0]) pad_byte = PAD_BYTE;
        else if (pad_idx_reg >= LEN_START && final_reg)
            pad_byte = len_reg[{~pad_idx_reg[2:0], 3'b000} +: 8];
        else pad_byte = 8'h00;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_axis_tuser == ACT_FINISH) state_next = ST_PAD;
                    else if (fill_reg == 7'd63) state_next = ST_ROUND;
                end
            end
            ST_PAD:   if (pad_idx_reg == 6'd63) state_next = ST_ROUND;
            ST_ROUND: if (round_reg == LAST_ROUND) state_next = ST_UPD;
            ST_UPD: begin
                if (second_reg) state_next = ST_PAD;
                else if (final_reg) state_next = ST_OUT;
                else state_next = ST_IDLE;
            end
            ST_OUT:   if (m_fire && out_idx_reg == 3'd7) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < 8; i++) chain_reg[i] <= initial_hash(3'(i));
            bit_count_reg <= '0;
            fill_reg <= '0;
            round_reg <= '0;
            final_reg <= 1'b0;
            second_reg <= 1'b0;
            out_idx_reg <= '0;
            pad_idx_reg <= '0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (s_axis_tuser == ACT_FINISH) begin
                            len_reg <= bit_count_reg;
                            pad_idx_reg <= fill_reg[5:0];
                            // length fits behind the pad byte only if fill <= 55
                            final_reg <= (fill_reg[5:0] < LEN_START);
                            second_reg <= (fill_reg[5:0] >= LEN_START);
                        end else begin
                            bit_count_reg <= bit_count_reg + 64'd8;
                            fill_reg <= fill_reg + 7'd1;
                            final_reg <= 1'b0;
                            second_reg <= 1'b0;
                        end
                    end
                end
                ST_PAD: begin
                    pad_idx_reg <= pad_idx_reg + 6'd1;
                end
                ST_ROUND: begin
                    round_reg <= round_reg + 6'd1;
                end
                ST_UPD: begin
                    for (int i = 0; i < 8; i++) chain_reg[i] <= chain_reg[i] + vars[i];
                    pad_idx_reg <= '0;
                    round_reg <= '0;
                    out_idx_reg <= '0;
                    if (second_reg) begin
                        // pad byte already placed, length block follows
                        second_reg <= 1'b0;
                        final_reg <= 1'b1;
                        fill_reg <= 7'd64;
                    end else if (!final_reg) begin
                        fill_reg <= '0;
                    end
                end
                ST_OUT: begin
                    if (m_fire) begin
                        out_idx_reg <= out_idx_reg + 3'd1;
                        if (out_idx_reg == 3'd7) begin
                            for (int i = 0; i < 8; i++) chain_reg[i] <= initial_hash(3'(i));
                            bit_count_reg <= '0;
                            fill_reg <= '0;
                            final_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // block bytes shift in big-endian, then the window slides one word per round
    assign shift_en = (s_fire && s_axis_tuser == ACT_ABSORB) || (state_reg == ST_PAD);
    assign shift_byte = (state_reg == ST_PAD) ? pad_byte : s_axis_tdata;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
                w_reg[i] <= {w_reg[i][23:0], w_reg[i + 1][31:24]};
            w_reg[BLOCK_WORDS - 1] <= {w_reg[BLOCK_WORDS - 1][23:0], shift_byte};
        end else if (state_reg == ST_ROUND) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) w_reg[i] <= w_reg[i + 1];
            w_reg[BLOCK_WORDS - 1] <= w_new;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND) |-> !s_axis_tready)
        else $error("input taken during compression");
    a_rounds_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && round_reg == LAST_ROUND) |=> (state_reg == ST_UPD))
        else $error("compression did not end after 64 rounds");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(out_idx_reg)))
        else $error("digest word moved while stalled");
`endif

endmodule
